@@ hw/rtl/sapg_pkg.sv @@
package sapg_pkg;

    localparam logic [2:0] FUNC_TICK    = 3'd0;
    localparam logic [2:0] FUNC_MOVE_ABS = 3'd1;
    localparam logic [2:0] FUNC_MOVE_REL = 3'd2;
    localparam logic [2:0] FUNC_STOP    = 3'd3;
    localparam logic [2:0] FUNC_SET_POS = 3'd4;

    localparam logic [1:0] REG_ACCEL = 2'd0;
    localparam logic [1:0] REG_FIRST = 2'd1;
    localparam logic [1:0] REG_MIN   = 2'd2;

    localparam logic [15:0] ACCEL_RESET = 16'd1;
    localparam logic [27:0] FIRST_RESET = 28'd256000000;
    localparam logic [27:0] MIN_RESET   = 28'd256;

    localparam logic [31:0] UMAX32 = 32'hFFFF_FFFF;
    localparam logic [31:0] RAMP_MAX = 32'h7FFF_FFFF;

    // request to the serial divider
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } div_rsp_t;

endpackage

@@ hw/rtl/stepper_accel_profile_generator.sv @@
// set position, idle ticks, unused codes and no-op moves give a result beat in the
// cycle after acceptance; a step tick, move or stop runs the speed divide, the square,
// the stopping-distance divide, decide and the interval divide, which is skipped at
// rest or on a ramp start; a zero interval skips the speed divide
// one item at a time: the next beat is taken the cycle after the result beat
// reset: async active low, motion state zero, registers at reset values; sts_reg, spd_reg not reset
module stepper_accel_profile_generator #(
    parameter int POS_BITS  = 32,
    parameter int FRAC_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          func,
    input  logic [31:0]         now_us,
    input  logic signed [31:0]  position,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                step_pulse,
    output logic                step_dir,
    output logic signed [31:0]  current_position,
    output logic                busy_res,
    output logic [31:0]         step_interval,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam logic [63:0] SPEED_NUM = 64'(64'd1000000 << FRAC_BITS);
    localparam logic [63:0] STS_CAP   = 64'h4000_0000_0000_0000;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SPD    = 4'd1;  // speed divide running
    localparam logic [3:0] S_SQR    = 4'd2;  // speed square running
    localparam logic [3:0] S_STS    = 4'd3;  // stopping distance divide
    localparam logic [3:0] S_DECIDE = 4'd4;  // ramp decision
    localparam logic [3:0] S_CN     = 4'd5;  // interval divide running
    localparam logic [3:0] S_OUT    = 4'd6;  // result beat waits
    localparam logic [3:0] S_STOP2  = 4'd7;  // stop: after sts, form target
    localparam logic [3:0] S_CN0    = 4'd8;  // interval divide start

    // configuration
    logic [15:0] accel_reg;
    logic [27:0] first_reg;
    logic [27:0] min_reg;
    logic [1:0]  reg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        unique case (reg_idx)
            sapg_pkg::REG_ACCEL: prdata = {16'd0, accel_reg};
            sapg_pkg::REG_FIRST: prdata = {4'd0, first_reg};
            sapg_pkg::REG_MIN:   prdata = {4'd0, min_reg};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg <= sapg_pkg::ACCEL_RESET;
            first_reg <= sapg_pkg::FIRST_RESET;
            min_reg   <= sapg_pkg::MIN_RESET;
        end
        else if (cfg_wr)
        begin
            if (reg_idx == sapg_pkg::REG_ACCEL)
                accel_reg <= pwdata[15:0];
            if (reg_idx == sapg_pkg::REG_FIRST)
                first_reg <= pwdata[27:0];
            if (reg_idx == sapg_pkg::REG_MIN)
                min_reg <= pwdata[27:0];
        end
    end

    // motion state
    logic [3:0]          state_reg, state_next;
    logic [POS_BITS-1:0] cur_reg, cur_next;
    logic [POS_BITS-1:0] tgt_reg, tgt_next;
    logic signed [31:0]  ramp_reg, ramp_next;
    logic [31:0]         intv_reg, intv_next;
    logic [31:0]         act_reg, act_next;
    logic                mov_reg, mov_next;
    logic                dir_reg, dir_next;
    logic [31:0]         last_reg, last_next;
    logic                pulse_reg, pulse_next;
    logic                stop_reg, stop_next;
    logic [63:0]         sts_reg, sts_next;
    logic [31:0]         spd_reg, spd_next;

    // serial units: a divider shared by the three divides, and a multiplier
    sapg_pkg::div_req_t dreq;
    sapg_pkg::div_rsp_t drsp;
    logic               mstart, mdone;
    logic [63:0]        mprod;
    logic               sqr_kick_reg;

    sapg_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));
    sapg_mul u_mul (.clk(clk), .rst_n(rst_n), .start(mstart), .a(spd_reg),
                    .b(spd_reg), .done(mdone), .prod(mprod));

    logic [POS_BITS-1:0] pos_ext, delta, stop_rel;
    logic                dist_neg, dist_nz, up, due;
    logic [POS_BITS-1:0] mag;
    logic [63:0]         mag64, sts_stop;
    logic [31:0]         sts32, elapsed;
    logic signed [33:0]  den_s;
    logic [33:0]         den_abs;
    logic [63:0]         cn_sum;
    logic [31:0]         cn_sat;
    logic [31:0]         accel_eff;

    assign pos_ext  = POS_BITS'($signed(position));
    assign delta    = tgt_reg - cur_reg;
    assign dist_neg = delta[POS_BITS-1];
    assign dist_nz  = delta != '0;
    assign up       = dist_nz && !dist_neg;
    assign mag      = dist_neg ? (~delta + 1'b1) : delta;
    assign mag64    = 64'(mag);
    assign sts32    = (sts_reg > 64'(sapg_pkg::RAMP_MAX)) ? sapg_pkg::RAMP_MAX
                                                          : sts_reg[31:0];
    assign elapsed  = now_us - last_reg;
    assign due      = (act_reg != '0) && (elapsed >= (act_reg >> FRAC_BITS));
    // divisor |4n+1| from the ramp count already updated by the decide step
    assign den_s    = 34'(ramp_reg) * 34'sd4 + 34'sd1;
    assign den_abs  = den_s[33] ? 34'(-den_s) : den_s;
    assign cn_sum   = ramp_reg > 0 ? 64'(intv_reg) - drsp.quo
                                   : 64'(intv_reg) + drsp.quo;
    assign cn_sat   = (cn_sum > 64'(sapg_pkg::UMAX32)) ? sapg_pkg::UMAX32 : cn_sum[31:0];
    assign accel_eff = (accel_reg == '0) ? 32'd1 : 32'(accel_reg);
    assign sts_stop = sts_reg + 64'd1;
    assign stop_rel = dir_reg ? POS_BITS'(sts_stop) : POS_BITS'(64'd0 - sts_stop);

    assign in_ready = (state_reg == S_IDLE);
    assign mstart   = sqr_kick_reg;

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        tgt_next   = tgt_reg;
        ramp_next  = ramp_reg;
        intv_next  = intv_reg;
        act_next   = act_reg;
        mov_next   = mov_reg;
        dir_next   = dir_reg;
        last_next  = last_reg;
        pulse_next = pulse_reg;
        stop_next  = stop_reg;
        sts_next   = sts_reg;
        spd_next   = spd_reg;
        dreq.start = 1'b0;
        dreq.num   = SPEED_NUM;
        dreq.den   = 64'(intv_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pulse_next = 1'b0;
                    stop_next  = 1'b0;
                    state_next = S_OUT;
                    unique case (func)
                        sapg_pkg::FUNC_TICK:
                        begin
                            if (due)
                            begin
                                cur_next   = dir_reg ? cur_reg + 1'b1 : cur_reg - 1'b1;
                                last_next  = now_us;
                                pulse_next = 1'b1;
                                state_next = S_SPD;
                            end
                        end
                        sapg_pkg::FUNC_MOVE_ABS:
                        begin
                            if (pos_ext != tgt_reg)
                            begin
                                tgt_next   = pos_ext;
                                state_next = S_SPD;
                            end
                        end
                        sapg_pkg::FUNC_MOVE_REL:
                        begin
                            if (cur_reg + pos_ext != tgt_reg)
                            begin
                                tgt_next   = cur_reg + pos_ext;
                                state_next = S_SPD;
                            end
                        end
                        sapg_pkg::FUNC_STOP:
                        begin
                            if (mov_reg)
                            begin
                                stop_next  = 1'b1;
                                state_next = S_SPD;
                            end
                        end
                        sapg_pkg::FUNC_SET_POS:
                        begin
                            cur_next  = pos_ext;
                            tgt_next  = pos_ext;
                            ramp_next = '0;
                            act_next  = '0;
                            mov_next  = 1'b0;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                    if (state_next == S_SPD)
                    begin
                        if (intv_reg == '0)
                        begin
                            spd_next   = sapg_pkg::UMAX32;
                            state_next = S_SQR;
                        end
                        else
                            dreq.start = 1'b1;
                    end
                end
            end
            S_SPD:
            begin
                if (drsp.done)
                begin
                    spd_next = (drsp.quo > 64'(sapg_pkg::UMAX32)) ? sapg_pkg::UMAX32
                                                                  : drsp.quo[31:0];
                    state_next = S_SQR;
                end
            end
            S_SQR:
            begin
                // multiplier is kicked in the first cycle in this state, once spd_reg holds the speed
                if (mdone)
                begin
                    dreq.start = 1'b1;
                    dreq.num   = mprod;
                    dreq.den   = 64'(accel_eff) << 1;
                    state_next = S_STS;
                end
            end
            S_STS:
            begin
                if (drsp.done)
                begin
                    sts_next   = (drsp.quo > STS_CAP) ? STS_CAP : drsp.quo;
                    state_next = stop_reg ? S_STOP2 : S_DECIDE;
                end
            end
            S_STOP2:
            begin
                stop_next = 1'b0;
                if (cur_reg + stop_rel != tgt_reg)
                begin
                    tgt_next   = cur_reg + stop_rel;
                    state_next = S_DECIDE;
                end
                else
                    state_next = S_OUT;
            end
            S_DECIDE:
            begin
                if (!dist_nz && sts_reg <= 64'd1)
                begin
                    act_next   = '0;
                    mov_next   = 1'b0;
                    ramp_next  = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    if (dist_nz)
                    begin
                        if (ramp_reg > 0)
                        begin
                            if (sts_reg >= mag64 || dir_reg != up)
                                ramp_next = -$signed(sts32);
                        end
                        else if (ramp_reg < 0)
                        begin
                            if (sts_reg < mag64 && dir_reg == up)
                                ramp_next = (ramp_reg == 32'sh8000_0000)
                                    ? $signed(sapg_pkg::RAMP_MAX) : -ramp_reg;
                        end
                    end
                    if (ramp_next == 0)
                    begin
                        intv_next = 32'(first_reg);
                        act_next  = 32'(first_reg);
                        dir_next  = up;
                        mov_next  = 1'b1;
                        ramp_next = 32'sd1;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_CN0;
                end
            end
            S_CN0:
            begin
                dreq.start = 1'b1;
                dreq.num   = 64'(intv_reg) << 1;
                dreq.den   = 64'(den_abs);
                state_next = S_CN;
            end
            S_CN:
            begin
                if (drsp.done)
                begin
                    intv_next = (cn_sat < 32'(min_reg)) ? 32'(min_reg) : cn_sat;
                    act_next  = intv_next;
                    mov_next  = 1'b1;
                    if (ramp_reg != $signed(sapg_pkg::RAMP_MAX))
                        ramp_next = ramp_reg + 32'sd1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // kick the multiplier, registered, in the first cycle of the square stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sqr_kick_reg <= 1'b0;
        else
            sqr_kick_reg <= (state_reg != S_SQR) && (state_next == S_SQR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cur_reg   <= '0;
            tgt_reg   <= '0;
            ramp_reg  <= '0;
            intv_reg  <= '0;
            act_reg   <= '0;
            mov_reg   <= 1'b0;
            dir_reg   <= 1'b0;
            last_reg  <= '0;
            pulse_reg <= 1'b0;
            stop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            tgt_reg   <= tgt_next;
            ramp_reg  <= ramp_next;
            intv_reg  <= intv_next;
            act_reg   <= act_next;
            mov_reg   <= mov_next;
            dir_reg   <= dir_next;
            last_reg  <= last_next;
            pulse_reg <= pulse_next;
            stop_reg  <= stop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sts_reg <= sts_next;
        spd_reg <= spd_next;
    end

    // result beat
    assign out_valid        = (state_reg == S_OUT);
    assign step_pulse       = pulse_reg;
    assign step_dir         = dir_reg;
    assign current_position = 32'($signed(cur_reg));
    assign busy_res         = mov_reg || dist_nz;
    assign step_interval    = act_reg;

    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
        else $error("input taken while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && step_pulse) |-> act_reg != '0 || !mov_reg)
        else $error("step with no interval");
    assert property (@(posedge clk) disable iff (!rst_n)
        !mov_reg |-> act_reg == '0)
        else $error("interval left active at rest");

endmodule

@@ hw/rtl/sapg_div.sv @@
module sapg_div (
    input  logic                clk,
    input  logic                rst_n,
    input  sapg_pkg::div_req_t  req,
    output sapg_pkg::div_rsp_t  rsp
);

    // one quotient bit per cycle, restoring
    logic [63:0] quo_reg, quo_next;
    logic [64:0] rem_reg, rem_next;
    logic [63:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg[63:0], quo_reg[63]};
        if (req.start)
        begin
            quo_next = req.num;
            rem_next = '0;
            den_next = req.den;
            cnt_next = 7'd64;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

    assert property (@(posedge clk) disable iff (!rst_n) rsp.done |-> !run_reg)
        else $error("divider done while running");
    assert property (@(posedge clk) disable iff (!rst_n) run_reg |-> cnt_reg != 7'd0)
        else $error("divider count underflow");
    assert property (@(posedge clk) disable iff (!rst_n) req.start |=> run_reg)
        else $error("divider did not start");

endmodule

@@ hw/rtl/sapg_mul.sv @@
module sapg_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [63:0] prod
);

    // shift-add, one multiplier bit per cycle
    logic [63:0] acc_reg, acc_next;
    logic [63:0] mcand_reg, mcand_next;
    logic [31:0] mplier_reg, mplier_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        run_next    = run_reg;
        done_next   = 1'b0;
        if (start)
        begin
            acc_next    = '0;
            mcand_next  = {32'd0, a};
            mplier_next = b;
            cnt_next    = 6'd32;
            run_next    = 1'b1;
        end
        else if (run_reg)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + mcand_reg;
            mcand_next  = {mcand_reg[62:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[31:1]};
            cnt_next    = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

@@ tb/sv/stepper_accel_profile_generator_tb.sv @@
module stepper_accel_profile_generator_tb;

    // codes 5 to 7 have no meaning and must leave the state alone
    localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
    localparam int CYCLE = 12;
    localparam int SETTLE_CYCLES = 600;
    localparam int HOLD_CYCLES = 3000;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    typedef struct {
        logic               pulse;
        logic               dir;
        logic signed [31:0] pos;
        logic               busy;
        logic [31:0]        interval;
    } step_report_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         func;
    logic [31:0]        now_us;
    logic signed [31:0] position;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               step_pulse;
    logic               step_dir;
    logic signed [31:0] current_position;
    logic               busy_res;
    logic [31:0]        step_interval;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    stepper_accel_profile_generator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .now_us(now_us), .position(position),
        .out_valid(out_valid), .out_ready(out_ready),
        .step_pulse(step_pulse), .step_dir(step_dir),
        .current_position(current_position), .busy_res(busy_res),
        .step_interval(step_interval),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow of the ramp generator state
    logic [15:0]        sh_accel;
    logic [27:0]        sh_first;
    logic [27:0]        sh_min;
    logic signed [31:0] sh_pos;
    logic signed [31:0] sh_target;
    int                 sh_ramp;
    logic [31:0]        sh_cn;
    logic [31:0]        sh_active;
    logic               sh_moving;
    logic               sh_dir;
    logic [31:0]        sh_last_step;

    step_report_t pending_reports[$];
    idle_mode_e   idle_mode;
    logic         hold_active;
    event         hold_go;
    int           mismatches = 0;

    // free-running clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // floor(speed^2 / 2a), speed in whole steps per second
    function automatic logic [63:0] stop_distance();
        logic [63:0] spd;
        logic [63:0] acc;
        logic [63:0] steps;
        if (sh_cn == 32'd0)
            spd = 64'hFFFF_FFFF;
        else
            spd = 64'd256000000 / {32'd0, sh_cn};
        if (spd > 64'hFFFF_FFFF)
            spd = 64'hFFFF_FFFF;
        // zero acceleration acts as one
        acc = (sh_accel != 16'd0) ? {48'd0, sh_accel} : 64'd1;
        steps = (spd * spd) / (2 * acc);
        return (steps > 64'h4000_0000_0000_0000) ? 64'h4000_0000_0000_0000 : steps;
    endfunction

    // next step interval from the ramp recurrence
    function automatic void update_ramp();
        logic signed [31:0] togo;
        logic [63:0]        sts;
        int                 sts32;
        longint             mag;
        longint             den;
        logic [63:0]        dd;
        logic [63:0]        quot;
        logic [63:0]        nxt;
        logic [31:0]        cn;
        logic               up;
        togo = sh_target - sh_pos;
        sts = stop_distance();
        sts32 = (sts > 64'd2147483647) ? 2147483647 : int'(sts);
        if (togo == 0 && sts <= 64'd1)
        begin
            sh_active = 32'd0;
            sh_moving = 1'b0;
            sh_ramp = 0;
            return;
        end
        if (togo != 0)
        begin
            up = (togo > 0);
            mag = up ? longint'(togo) : -longint'(togo);
            if (sh_ramp > 0)
            begin
                // decelerate when close or heading the wrong way
                if (longint'(sts) >= mag || sh_dir != up)
                    sh_ramp = -sts32;
            end
            else if (sh_ramp < 0)
            begin
                if (longint'(sts) < mag && sh_dir == up)
                    sh_ramp = (sh_ramp == -2147483648) ? 2147483647 : -sh_ramp;
            end
        end
        if (sh_ramp == 0)
        begin
            cn = {4'd0, sh_first};
            sh_dir = (togo > 0);
        end
        else
        begin
            den = 4 * longint'(sh_ramp) + 1;
            dd = (den < 0) ? -den : den;
            quot = (2 * {32'd0, sh_cn}) / dd;
            nxt = (sh_ramp > 0) ? ({32'd0, sh_cn} - quot) : ({32'd0, sh_cn} + quot);
            if (nxt > 64'hFFFF_FFFF)
                nxt = 64'hFFFF_FFFF;
            cn = nxt[31:0];
            if (cn < {4'd0, sh_min})
                cn = {4'd0, sh_min};
        end
        sh_cn = cn;
        // ramp count saturates at the top
        if (sh_ramp < 2147483647)
            sh_ramp++;
        sh_active = cn;
        sh_moving = 1'b1;
    endfunction

    function automatic void seek(logic signed [31:0] dest);
        if (dest == sh_target)
            return;
        sh_target = dest;
        update_ramp();
    endfunction

    function automatic step_report_t predict_step(logic [2:0] fn, logic [31:0] now,
                                                  logic signed [31:0] arg);
        step_report_t rep;
        logic [63:0]  runout;
        rep.pulse = 1'b0;
        case (fn)
            sapg_pkg::FUNC_TICK:
                if (sh_active != 32'd0 && (now - sh_last_step) >= (sh_active >> 8))
                begin
                    sh_pos = sh_pos + (sh_dir ? 32'sd1 : -32'sd1);
                    sh_last_step = now;
                    rep.pulse = 1'b1;
                    update_ramp();
                end
            sapg_pkg::FUNC_MOVE_ABS: seek(arg);
            sapg_pkg::FUNC_MOVE_REL: seek(sh_pos + arg);
            sapg_pkg::FUNC_STOP:
                if (sh_moving)
                begin
                    runout = stop_distance() + 64'd1;
                    if (!sh_dir)
                        runout = -runout;
                    seek(sh_pos + runout[31:0]);
                end
            sapg_pkg::FUNC_SET_POS:
            begin
                sh_pos = arg;
                sh_target = arg;
                sh_ramp = 0;
                sh_active = 32'd0;
                sh_moving = 1'b0;
            end
            default: ;
        endcase
        rep.dir = sh_dir;
        rep.pos = sh_pos;
        rep.busy = sh_moving || (sh_target != sh_pos);
        rep.interval = sh_active;
        return rep;
    endfunction

    // one input beat, with an optional gap before it
    task automatic send_command(logic [2:0] fn, logic [31:0] now, logic signed [31:0] arg);
        int gap;
        gap = 0;
        if (idle_mode == IDLE_SEND && $urandom_range(99) < 46)
            gap = $urandom_range(1, 4);
        else if (idle_mode == IDLE_BOTH && $urandom_range(99) < 29)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= fn;
        now_us <= now;
        position <= arg;
        do
            @(posedge clk);
        while (!in_ready);
        pending_reports.push_back(predict_step(fn, now, arg));
    endtask

    // tick at a time chosen from the shadow state so a step is due or not
    task automatic send_tick(bit due);
        logic [31:0] need;
        logic [31:0] now;
        need = sh_active >> 8;
        if (due || need == 32'd0)
            now = sh_last_step + need + $urandom_range(0, 3);
        else
            now = sh_last_step + $urandom_range(0, need - 1);
        send_command(sapg_pkg::FUNC_TICK, now, $urandom);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            sapg_pkg::REG_ACCEL: sh_accel = data[15:0];
            sapg_pkg::REG_FIRST: sh_first = data[27:0];
            sapg_pkg::REG_MIN:   sh_min = data[27:0];
            default: ;
        endcase
    endtask

    task automatic load_profile(logic [15:0] acc, logic [27:0] first, logic [27:0] lo);
        apb_write(sapg_pkg::REG_ACCEL, {16'd0, acc});
        apb_write(sapg_pkg::REG_FIRST, {4'd0, first});
        apb_write(sapg_pkg::REG_MIN, {4'd0, lo});
    endtask

    // mostly ticks, largely due, with some moves (mostly short), stops, resets and noise
    task automatic run_random(int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_tick($urandom_range(9) != 0);
            else if (pick < 80)
                send_command(sapg_pkg::FUNC_MOVE_REL, $urandom,
                             $signed($urandom_range(0, 80)) - 40);
            else if (pick < 84)
                send_command(sapg_pkg::FUNC_MOVE_ABS, $urandom,
                             ($urandom_range(3) == 0) ? $urandom
                                                       : sh_pos + $urandom_range(0, 60) - 30);
            else if (pick < 89)
                send_command(sapg_pkg::FUNC_STOP, $urandom, $urandom);
            else if (pick < 93)
                send_command(sapg_pkg::FUNC_SET_POS, $urandom, $urandom);
            else
                send_command(3'($urandom_range(0, 7)), $urandom, $urandom);
        end
    endtask

    task automatic test_directed();
        load_profile(16'd1000, 28'd8095488, 28'd25600);
        send_command(sapg_pkg::FUNC_TICK, 32'd0, 32'sd0);            // tick at rest
        send_command(sapg_pkg::FUNC_SET_POS, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
        send_command(sapg_pkg::FUNC_MOVE_REL, 32'd0, 32'sd3);        // wraps past the top
        send_tick(1);
        send_tick(0);                                                // step not yet due
        send_tick(1);
        send_command(sapg_pkg::FUNC_SET_POS, 32'd0, 32'sh8000_0000);
        send_command(sapg_pkg::FUNC_MOVE_ABS, 32'd0, 32'sh8000_0000); // same target
        send_command(sapg_pkg::FUNC_STOP, 32'd0, 32'sd0);             // stop at rest
        send_command(sapg_pkg::FUNC_MOVE_ABS, 32'd0, 32'sh7FFF_FFFF); // one step down, across the signed wrap
        send_tick(1);
        send_tick(1);
        send_command(sapg_pkg::FUNC_MOVE_REL, 32'd0, -32'sd20);       // twenty steps down
        send_tick(1);
        send_command(sapg_pkg::FUNC_STOP, 32'd0, 32'sd0);
        send_tick(1);
        send_command(sapg_pkg::FUNC_MOVE_REL, 32'd0, 32'sd0);
        for (logic [2:0] c = FUNC_SPARE_LO; c <= FUNC_SPARE_HI && c != 3'd0; c++)
            send_command(c, 32'hFFFF_FFFF, 32'shFFFF_FFFF);
        // time wraps between steps
        send_command(sapg_pkg::FUNC_SET_POS, 32'd0, 32'sd0);
        send_command(sapg_pkg::FUNC_MOVE_REL, 32'd0, 32'sd5);
        send_command(sapg_pkg::FUNC_TICK, 32'hFFFF_FFF0 + sh_last_step, 32'sd0);
        send_tick(1);
        wait_drained();
    endtask

    task automatic test_profiles();
        idle_mode_e modes[4];
        modes = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: load_profile(16'd1000, 28'd8095488, 28'd256);
                1: load_profile(16'd65535, 28'd256, 28'd256);             // fastest corner
                2: load_profile(16'd1, 28'hFFF_FFFF, 28'hFFF_FFFF);       // slowest corner
                3: load_profile(16'd0, 28'd256000000, 28'd2560);          // zero acceleration
                4: load_profile(16'd400, 28'd12800000, 28'd256000000);
                default: load_profile(16'($urandom_range(1, 65535)),
                                      28'($urandom_range(256, 2000000)),
                                      28'($urandom_range(256, 9000)));
            endcase
            idle_mode = modes[p % 4];
            send_command(sapg_pkg::FUNC_SET_POS, $urandom, $urandom);
            run_random(190);
            wait_drained();
        end
    endtask

    // receiver holds off long enough for the block to back up into its input
    task automatic test_backpressure();
        idle_mode = IDLE_NONE;
        load_profile(16'd5000, 28'd3620386, 28'd512);
        -> hold_go;
        send_command(sapg_pkg::FUNC_MOVE_REL, 32'd0, 32'sd25);
        for (int i = 0; i < 40; i++)
            send_tick(1);
        // sender waits until every report is back
        wait_drained();
        send_command(sapg_pkg::FUNC_MOVE_REL, 32'd0, -32'sd25);
        run_random(30);
        wait_drained();
    endtask

    // long receiver hold, counted in cycles here
    initial
    begin
        hold_active = 1'b0;
        forever
        begin
            @(hold_go);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active <= 1'b0;
        end
    end

    // reports land here, checked against the oldest prediction
    always @(posedge clk)
    begin
        step_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: pos %0d interval %0d",
                             current_position, step_interval);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (step_pulse !== want.pulse || step_dir !== want.dir
                    || current_position !== want.pos || busy_res !== want.busy
                    || step_interval !== want.interval)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp pulse %0b dir %0b pos %0d busy %0b",
                                  " intv %0d, got %0b %0b %0d %0b %0d"},
                                 want.pulse, want.dir, want.pos, want.busy,
                                 want.interval, step_pulse, step_dir,
                                 current_position, busy_res, step_interval);
                end
            end
        end
        // receiver side stalls
        if (hold_active)
            out_ready <= 1'b0;
        else if (idle_mode == IDLE_RECV)
            out_ready <= ($urandom_range(99) >= 46);
        else if (idle_mode == IDLE_BOTH)
            out_ready <= ($urandom_range(99) >= 29);
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = sapg_pkg::FUNC_TICK;
        now_us = 32'd0;
        position = 32'sd0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 4'd0;
        pwdata = 32'd0;
        idle_mode = IDLE_NONE;
        sh_accel = sapg_pkg::ACCEL_RESET;
        sh_first = sapg_pkg::FIRST_RESET;
        sh_min = sapg_pkg::MIN_RESET;
        sh_pos = 32'sd0;
        sh_target = 32'sd0;
        sh_ramp = 0;
        sh_cn = 32'd0;
        sh_active = 32'd0;
        sh_moving = 1'b0;
        sh_dir = 1'b0;
        sh_last_step = 32'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_profiles();
        test_backpressure();
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("stepper_accel_profile_generator_tb: done, clean");
        else
            $display("stepper_accel_profile_generator_tb: done, errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #(CYCLE * 30000000);
        $display("stepper_accel_profile_generator_tb: done, errors");
        $finish;
    end

endmodule
